@@ src/plin_pkg.sv @@
// ---------------------------------------------------------------------------
// plin_pkg
// Shared types and constants of the piecewise linear interpolation unit.
// ---------------------------------------------------------------------------
package plin_pkg;

  localparam int MAX_POINTS = 64;
  localparam int IDX_W      = $clog2(MAX_POINTS);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  localparam logic [1:0] REG_INTERP = 2'd0;
  localparam logic [1:0] REG_LEFT   = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_EXACT  = 2'd3;

  localparam logic [2:0] CFG_POINT_COUNT   = 3'd0;
  localparam logic [2:0] CFG_LEFT_FILL_ON  = 3'd1;
  localparam logic [2:0] CFG_LEFT_FILL     = 3'd2;
  localparam logic [2:0] CFG_RIGHT_FILL_ON = 3'd3;
  localparam logic [2:0] CFG_RIGHT_FILL    = 3'd4;

  typedef struct packed {
    logic        is_eval;
    logic [5:0]  point_index;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] query_x;
  } item_t;

  typedef struct packed {
    logic [6:0]  point_count;
    logic        left_fill_on;
    logic [31:0] left_fill;
    logic        right_fill_on;
    logic [31:0] right_fill;
  } cfg_t;

endpackage

@@ src/piecewise_linear_interp_unit.sv @@
// ---------------------------------------------------------------------------
// piecewise_linear_interp_unit
// Piecewise linear interpolation over a loaded Q16.16 breakpoint table.
//
//  channel  direction  request
//  s_*      in         tuser operation; tdata point_index/x/y, query_x
//  m_*      out        tuser region; tdata y_value
//  apb      in         point_count, fills and fill enables
//
// A breakpoint write is taken by the back end while it is idle. A query reads
// the first slot for a left-fill answer, then the last slot for a right-fill
// or last-point one; an interpolated one also scans the table down from the
// last slot, reading and then checking each slot in turn through the RAM port,
// then runs a bit-serial divider. The back end works on one request at a time.
// Reset is synchronous; the table contents are undefined until written. The
// two-entry queue lets input keep flowing while the back end works or its
// result stalls.
module piecewise_linear_interp_unit
  import plin_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // point_index, point_x, point_y, query_x, zero pad
  input  logic         s_tuser,   // operation
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata,   // y_value
  output logic [1:0]   m_tuser,   // region
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  logic  item_pop;
  logic  cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.point_count   <= 7'd1;
      cfg.left_fill_on  <= 1'b0;
      cfg.left_fill     <= '0;
      cfg.right_fill_on <= 1'b0;
      cfg.right_fill    <= '0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        CFG_POINT_COUNT:   cfg.point_count   <= pwdata[6:0];
        CFG_LEFT_FILL_ON:  cfg.left_fill_on  <= pwdata[0];
        CFG_LEFT_FILL:     cfg.left_fill     <= pwdata;
        CFG_RIGHT_FILL_ON: cfg.right_fill_on <= pwdata[0];
        CFG_RIGHT_FILL:    cfg.right_fill    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      CFG_POINT_COUNT:   prdata = {25'd0, cfg.point_count};
      CFG_LEFT_FILL_ON:  prdata = {31'd0, cfg.left_fill_on};
      CFG_LEFT_FILL:     prdata = cfg.left_fill;
      CFG_RIGHT_FILL_ON: prdata = {31'd0, cfg.right_fill_on};
      CFG_RIGHT_FILL:    prdata = cfg.right_fill;
      default:           prdata = '0;
    endcase
  end

  plin_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  plin_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .cfg        (cfg),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

@@ src/plin_ram.sv @@
// ---------------------------------------------------------------------------
// plin_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module plin_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/plin_front.sv @@
// ---------------------------------------------------------------------------
// plin_front
// Accepts requests, decodes them and holds them in a two-entry queue.
// ---------------------------------------------------------------------------
module plin_front
  import plin_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // point_index, point_x, point_y, query_x, zero pad
  input  logic         s_tuser,   // operation
  output item_t        item,
  output logic         item_valid,
  input  logic         item_pop
);

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  item_t      dec;

  assign s_tready   = (fill != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign item_valid = (fill != 2'd0);
  assign item       = slot[rd_ptr];

  always_comb begin
    dec.is_eval     = (s_tuser == OP_EVAL);
    dec.point_index = s_tdata[5:0];
    dec.point_x     = s_tdata[37:6];
    dec.point_y     = s_tdata[69:38];
    dec.query_x     = s_tdata[101:70];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, item_pop};
    end
  end

endmodule

@@ src/plin_back.sv @@
// ---------------------------------------------------------------------------
// plin_back
// Breakpoint table, segment scan, multiply, iterative divide and result
// register.
// ---------------------------------------------------------------------------
module plin_back
  import plin_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  item_t       item,
  input  logic        item_valid,
  output logic        item_pop,
  input  cfg_t        cfg,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // y_value
  output logic [1:0]  m_tuser    // region
);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_FIRST, S_CHK_FIRST, S_RD_LAST, S_CHK_LAST,
    S_RD_SCAN, S_CHK_SCAN, S_PREP, S_MUL, S_DIV, S_FIN, S_EMIT
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   addr;
  logic [IDX_W-1:0]   last;
  logic signed [31:0] q, x0, y0, x1, y1, res;
  logic [1:0]         region;
  logic [31:0]        dx, dd, mag;
  logic               neg;
  logic [63:0]        prod;
  logic [31:0]        rem, quo;
  logic [5:0]         step;

  logic               we;
  logic [63:0]        rdata;
  logic signed [31:0] rx, ry;
  logic [32:0]        dy;
  logic [32:0]        trial;
  logic [32:0]        diff;
  logic signed [33:0] sum;

  assign rx = rdata[31:0];
  assign ry = rdata[63:32];

  assign we       = (state == S_IDLE) && item_valid && !item.is_eval
                    && (int'(item.point_index) < MAX_POINTS);
  assign item_pop = (state == S_IDLE) && item_valid;

  always_comb begin
    if (cfg.point_count == 7'd0) begin
      last = '0;
    end else if (int'(cfg.point_count) > MAX_POINTS) begin
      last = IDX_W'(MAX_POINTS - 1);
    end else begin
      last = IDX_W'(cfg.point_count - 7'd1);
    end
  end

  plin_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (IDX_W'(item.point_index)),
    .wdata ({item.point_y, item.point_x}),
    .raddr (addr),
    .rdata (rdata)
  );

  assign dy    = {y1[31], y1} - {y0[31], y0};
  assign trial = {rem, prod[63]};
  assign diff  = trial - {1'b0, dd};
  assign sum   = neg ? ({{2{y0[31]}}, y0} - {2'b00, quo})
                     : ({{2{y0[31]}}, y0} + {2'b00, quo});

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid && item.is_eval) begin
            q     <= item.query_x;
            addr  <= '0;
            state <= S_RD_FIRST;
          end
        end
        S_RD_FIRST: state <= S_CHK_FIRST;
        S_CHK_FIRST: begin
          if (q < rx) begin
            res    <= cfg.left_fill_on ? cfg.left_fill : ry;
            region <= REG_LEFT;
            state  <= S_EMIT;
          end else begin
            addr  <= last;
            state <= S_RD_LAST;
          end
        end
        S_RD_LAST: state <= S_CHK_LAST;
        S_CHK_LAST: begin
          if (q > rx) begin
            res    <= cfg.right_fill_on ? cfg.right_fill : ry;
            region <= REG_RIGHT;
            state  <= S_EMIT;
          end else if (rx <= q) begin
            res    <= ry;
            region <= REG_EXACT;
            state  <= S_EMIT;
          end else begin
            x1    <= rx;
            y1    <= ry;
            addr  <= addr - 1'b1;
            state <= S_RD_SCAN;
          end
        end
        S_RD_SCAN: state <= S_CHK_SCAN;
        S_CHK_SCAN: begin
          if (rx <= q) begin
            x0 <= rx;
            y0 <= ry;
            if (rx == q) begin
              res    <= ry;
              region <= REG_EXACT;
              state  <= S_EMIT;
            end else begin
              state <= S_PREP;
            end
          end else begin
            x1    <= rx;
            y1    <= ry;
            addr  <= addr - 1'b1;
            state <= S_RD_SCAN;
          end
        end
        S_PREP: begin
          dx    <= 32'(q - x0);
          dd    <= 32'(x1 - x0);
          neg   <= dy[32];
          mag   <= dy[32] ? 32'(-dy) : dy[31:0];
          state <= S_MUL;
        end
        S_MUL: begin
          prod  <= dx * mag;
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (step == 6'd0) begin
            // high half is already below the divisor
            rem  <= prod[63:32];
            prod <= {prod[31:0], 32'd0};
            step <= 6'd1;
          end else begin
            if (!diff[32]) begin
              rem <= diff[31:0];
            end else begin
              rem <= trial[31:0];
            end
            quo  <= {quo[30:0], !diff[32]};
            prod <= {prod[62:0], 1'b0};
            step <= step + 6'd1;
            if (step == 6'd32) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (sum > 34'sh0_7FFF_FFFF) begin
            res <= 32'sh7FFF_FFFF;
          end else if (sum < -34'sh0_8000_0000) begin
            res <= 32'sh8000_0000;
          end else begin
            res <= sum[31:0];
          end
          region <= REG_INTERP;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= res;
            m_tuser  <= region;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/interp_checker.sv @@
// ---------------------------------------------------------------------------
// interp_checker
// Watches the request, result and register ports of the interpolation unit.
// Keeps its own breakpoint table and register copy, computes the expected
// y_value and region of every evaluate request, and compares each result in
// order. Reports the failure count and the number of results still owed.
// ---------------------------------------------------------------------------
module interp_checker
  import plin_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [103:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [31:0]  m_tdata,
  input  logic [1:0]   m_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fails,
  output int           owed
);

  typedef struct packed {
    logic [31:0] y_value;
    logic [1:0]  region;
  } answer_t;

  logic [31:0] tbl_x [MAX_POINTS];
  logic [31:0] tbl_y [MAX_POINTS];
  cfg_t        cfg;
  answer_t     answers_due [$];

  function automatic answer_t evaluate_at(logic [31:0] qx);
    answer_t   a;
    int        n, last, k;
    longint    q, x0, y0, x1, y1, dx, dd, dy, yy;
    bit [63:0] mag, quo;
    n = cfg.point_count;
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    last = n - 1;
    q = $signed(qx);
    if (q < longint'($signed(tbl_x[0]))) begin
      a.y_value = cfg.left_fill_on ? cfg.left_fill : tbl_y[0];
      a.region  = REG_LEFT;
    end else if (q > longint'($signed(tbl_x[last]))) begin
      a.y_value = cfg.right_fill_on ? cfg.right_fill : tbl_y[last];
      a.region  = REG_RIGHT;
    end else begin
      k = 0;
      for (int i = 1; i < n; i++)
        if (longint'($signed(tbl_x[i])) <= q) k = i;
      x0 = $signed(tbl_x[k]);
      y0 = $signed(tbl_y[k]);
      if (k == last || x0 == q) begin
        a.y_value = tbl_y[k];
        a.region  = REG_EXACT;
      end else begin
        x1  = $signed(tbl_x[k+1]);
        y1  = $signed(tbl_y[k+1]);
        dx  = q - x0;
        dd  = x1 - x0;
        dy  = y1 - y0;
        mag = (dy < 0) ? 64'(-dy) : 64'(dy);
        quo = (64'(dx) * mag) / 64'(dd);
        yy  = (dy < 0) ? y0 - longint'(quo) : y0 + longint'(quo);
        if (yy > 64'sd2147483647) yy = 64'sd2147483647;
        if (yy < -64'sd2147483648) yy = -64'sd2147483648;
        a.y_value = yy[31:0];
        a.region  = REG_INTERP;
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      cfg <= '{point_count: 7'd1, default: '0};
      answers_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          CFG_POINT_COUNT:   cfg.point_count   <= pwdata[6:0];
          CFG_LEFT_FILL_ON:  cfg.left_fill_on  <= pwdata[0];
          CFG_LEFT_FILL:     cfg.left_fill     <= pwdata;
          CFG_RIGHT_FILL_ON: cfg.right_fill_on <= pwdata[0];
          CFG_RIGHT_FILL:    cfg.right_fill    <= pwdata;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (answers_due.size() == 0) begin
          $display("%0t unexpected result y=%h region=%0d", $time, m_tdata, m_tuser);
          fails++;
        end else begin
          want = answers_due.pop_front();
          if (want.y_value !== m_tdata || want.region !== m_tuser) begin
            $display("%0t mismatch: expected y=%h region=%0d, got y=%h region=%0d",
                     $time, want.y_value, want.region, m_tdata, m_tuser);
            fails++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_EVAL) answers_due.push_back(evaluate_at(s_tdata[101:70]));
        else begin
          tbl_x[s_tdata[5:0]] = s_tdata[37:6];
          tbl_y[s_tdata[5:0]] = s_tdata[69:38];
        end
      end
    end
    owed = answers_due.size();
  end

  initial begin
    fails = 0;
    owed  = 0;
  end

endmodule

@@ tb/tb.sv @@
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the piecewise linear interpolation unit.
// Loads breakpoint tables, sweeps register settings and sends evaluate
// requests aimed at fills, exact points and segment interiors, with random
// gaps on both streams and one long result stall. Checking is in the checker.
// ---------------------------------------------------------------------------
module tb;
  import plin_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int SETTLE       = 200;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [103:0] s_tdata;   // point_index, point_x, point_y, query_x, zero pad
  logic         s_tuser;   // operation
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;   // y_value
  logic [1:0]   m_tuser;   // region
  logic         psel, penable, pwrite, pready;
  logic [4:0]   paddr;
  logic [31:0]  pwdata, prdata;

  int fails, owed, cycles, sent;
  bit quiet, hold_req, hold_used;
  logic [31:0] mir_x [MAX_POINTS];
  int          live_n;

  piecewise_linear_interp_unit u_top (.*);

  interp_checker u_chk (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fails, .owed
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    m_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1;
        m_tready <= 1'b0;
        repeat (400) @(negedge clk);
        m_tready <= 1'b1;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end
    end
  end

  task automatic send_request(logic op, logic [5:0] idx, logic [31:0] px,
                              logic [31:0] py, logic [31:0] qx);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, qx, py, px, idx};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (op == OP_WRITE) mir_x[idx] = px;
    sent++;
  endtask

  task automatic apb_write(logic [2:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_table(int n);
    int          vals [$];
    int          mode;
    int          base;
    logic [31:0] yv;
    mode = $urandom_range(0, 3);
    base = int'($urandom) >>> 4;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0, 2:    vals.push_back(int'($urandom));
        1:       vals.push_back(base + int'($urandom_range(0, 4 * n)));
        default: vals.push_back(base + i * int'($urandom_range(1, 70000)));
      endcase
    end
    if (mode != 2) begin
      vals.sort();
      for (int i = 1; i < n; i++)
        if (vals[i] <= vals[i-1]) vals[i] = vals[i-1] + 1;
    end
    for (int i = 0; i < n; i++) begin
      yv = $urandom_range(0, 1) ? $urandom : 32'($signed($urandom_range(0, 400000)) - 200000);
      send_request(OP_WRITE, i[5:0], vals[i], yv, 32'h0);
    end
  endtask

  function automatic logic [31:0] pick_query();
    longint    lo, hi, q;
    int        k;
    bit [63:0] r;
    k  = $urandom_range(0, live_n - 1);
    lo = $signed(mir_x[k]);
    case ($urandom_range(0, 9))
      0: begin
        q = longint'($signed(mir_x[0])) - 1 - $urandom_range(0, 1000);
        if (q < -64'sd2147483648) q = -64'sd2147483648;
      end
      1: begin
        q = longint'($signed(mir_x[live_n-1])) + 1 + $urandom_range(0, 1000);
        if (q > 64'sd2147483647) q = 64'sd2147483647;
      end
      2: q = lo;
      8: q = $signed($urandom);
      9: q = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
      default: begin
        q = lo;
        if (k < live_n - 1) begin
          hi = $signed(mir_x[k+1]);
          r  = {$urandom, $urandom};
          if (hi > lo) q = lo + longint'(r % 64'(hi - lo));
        end
      end
    endcase
    return q[31:0];
  endfunction

  initial begin
    int          cnt, items;
    logic [6:0]  cnt_reg;
    rst = 1'b1;
    s_tvalid = 1'b0; s_tuser = 1'b0; s_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: fills at the extremes, exact points, both slopes
    apb_write(CFG_POINT_COUNT, 32'd4);
    apb_write(CFG_LEFT_FILL_ON, 32'd1);
    apb_write(CFG_LEFT_FILL, 32'h8000_0000);
    apb_write(CFG_RIGHT_FILL_ON, 32'd1);
    apb_write(CFG_RIGHT_FILL, 32'h7fff_ffff);
    send_request(OP_WRITE, 6'd0, 32'hfffc_0000, 32'h7fff_ffff, 32'h0);
    send_request(OP_WRITE, 6'd1, 32'h0000_0000, 32'h8000_0000, 32'h0);
    send_request(OP_WRITE, 6'd2, 32'h0001_8000, 32'h0001_0000, 32'h0);
    send_request(OP_WRITE, 6'd3, 32'h0003_0000, 32'hffff_fffb, 32'h0);
    live_n = 4;
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'h8000_0000);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'h7fff_ffff);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'hfffc_0000);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'h0003_0000);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'h0001_8000);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'hfffe_0000);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'h0000_8000);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'h0002_0000);
    settle();
    apb_write(CFG_LEFT_FILL_ON, 32'd0);
    apb_write(CFG_RIGHT_FILL_ON, 32'd0);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'h8000_0000);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'h7fff_ffff);
    settle();
    // count zero behaves as a single point
    apb_write(CFG_POINT_COUNT, 32'd0);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'hffff_0000);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'hfffc_0000);
    send_request(OP_EVAL, 6'd0, 32'h0, 32'h0, 32'h0000_0001);

    // random phases
    items = 0;
    for (int ph = 0; items < RANDOM_ITEMS; ph++) begin
      settle();
      case (ph == 1 ? 2 : $urandom_range(0, 7))
        0:       cnt_reg = 7'd0;
        1:       cnt_reg = 7'd127;
        2:       cnt_reg = 7'd64;
        3:       cnt_reg = 7'd1;
        default: cnt_reg = 7'($urandom_range(2, 12));
      endcase
      cnt = (cnt_reg == 0) ? 1 : (cnt_reg > 64 ? 64 : cnt_reg);
      apb_write(CFG_POINT_COUNT, {25'd0, cnt_reg});
      apb_write(CFG_LEFT_FILL_ON, 32'($urandom_range(0, 1)));
      apb_write(CFG_LEFT_FILL, $urandom_range(0, 3) == 0 ? 32'h8000_0000 : $urandom);
      apb_write(CFG_RIGHT_FILL_ON, 32'($urandom_range(0, 1)));
      apb_write(CFG_RIGHT_FILL, $urandom_range(0, 3) == 0 ? 32'h7fff_ffff : $urandom);
      load_table(cnt);
      live_n = cnt;
      items += cnt;
      if (ph == 2) hold_req = 1;
      repeat ($urandom_range(30, 90)) begin
        if ($urandom_range(0, 9) == 0)
          send_request(OP_WRITE, 6'($urandom_range(0, cnt - 1)), $urandom, $urandom, $urandom);
        else
          send_request(OP_EVAL, 6'($urandom), $urandom, $urandom, pick_query());
        items++;
      end
      if (items > RANDOM_ITEMS - 150) quiet = 1;
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (owed != 0);
    repeat (SETTLE) @(posedge clk);
    if (fails == 0 && owed == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
